[hdl/peb_pkg.sv]
`default_nettype none

package peb_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 31;

   // register indexes on the configuration port
   localparam logic [CSR_INDEX_W-1:0] CSR_GRAVITY     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DAMPING     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_EXT_X  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_EXT_Y  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HALF_EXT_Z  = 3'd4;

   localparam logic [30:0] GRAVITY_RST    = 31'd196608;
   localparam logic [61:0] GRAVITY_SQ_RST = 62'd38654705664;
   localparam logic [16:0] DAMPING_RST    = 17'd65536;
   localparam logic [30:0] HALF_EXT_RST   = 31'd655360;

   localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   typedef struct packed {
      logic [61:0]       gravity_sq;
      logic [16:0]       damping;
      logic [2:0][30:0]  half_ext;
   } csr_type;

   typedef struct packed {
      logic [2:0][31:0]  pos;
      logic [2:0][31:0]  vel;
      logic [2:0][30:0]  size;
   } particle_type;

   // clamp a signed value to the signed 32-bit range
   function automatic logic [31:0] sat32(input logic signed [63:0] x);
      logic [32:0] upper;
      upper = x[63:31];
      if (upper == '0 || upper == '1) begin
         return x[31:0];
      end else if (x[63]) begin
         return SAT_MIN;
      end else begin
         return SAT_MAX;
      end
   endfunction

endpackage

`default_nettype wire

[hdl/peb_csr.sv]
`default_nettype none

module peb_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [peb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [peb_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output peb_pkg::csr_type                 csr
);
   import peb_pkg::*;

   logic [30:0]      gravity_ff;
   logic [61:0]      gravity_sq_ff, gravity_sq_in;
   logic [16:0]      damping_ff;
   logic [2:0][30:0] half_ext_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff  <= GRAVITY_RST;
         damping_ff  <= DAMPING_RST;
         half_ext_ff <= {3{HALF_EXT_RST}};
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_GRAVITY:    gravity_ff     <= csr_wdata[30:0];
            CSR_DAMPING:    damping_ff     <= csr_wdata[16:0];
            CSR_HALF_EXT_X: half_ext_ff[0] <= csr_wdata[30:0];
            CSR_HALF_EXT_Y: half_ext_ff[1] <= csr_wdata[30:0];
            CSR_HALF_EXT_Z: half_ext_ff[2] <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // square is only needed two stages into the pipe
   assign gravity_sq_in = gravity_ff * gravity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_sq_ff <= GRAVITY_SQ_RST;
      end else begin
         gravity_sq_ff <= gravity_sq_in;
      end
   end

   assign csr.gravity_sq = gravity_sq_ff;
   assign csr.damping    = damping_ff;
   assign csr.half_ext   = half_ext_ff;

endmodule

`default_nettype wire

[hdl/peb_integrate.sv]
`default_nettype none

module peb_integrate #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  peb_pkg::particle_type  in_p,
   input  logic [16:0]            in_dt,
   input  peb_pkg::csr_type       csr,
   output logic                   out_valid,
   input  logic                   out_ready,
   output peb_pkg::particle_type  out_p
);
   import peb_pkg::*;

   localparam int HI_W   = 33;
   localparam int LODT_W = FRAC_BITS + 17;

   logic [3:0] vld_ff, vld_in, rdy;

   // stage 1: displacement products
   particle_type       part1_ff, part1_in;
   logic [16:0]        dt1_ff;
   logic signed [49:0] prod1_ff [3];
   logic signed [49:0] prod1_in [3];
   // stage 2: moved position
   particle_type       part2_ff, part2_in;
   logic [16:0]        dt2_ff;
   // stage 3: gravity term partial products
   particle_type       part3_ff;
   logic [49:0]        hidt3_ff, hidt3_in;
   logic [LODT_W-1:0]  lodt3_ff, lodt3_in;
   logic               big3_ff, big3_in;
   // stage 4: gravity applied
   particle_type       part4_ff, part4_in;

   logic [61:0]        g2;
   logic [61:0]        g2_hi;
   logic signed [63:0] pos_sum [3];
   logic [50:0]        term;
   logic signed [63:0] vy_diff;

   always_comb begin
      rdy[3] = !vld_ff[3] || out_ready;
      rdy[2] = !vld_ff[2] || rdy[3];
      rdy[1] = !vld_ff[1] || rdy[2];
      rdy[0] = !vld_ff[0] || rdy[1];
      vld_in[0] = rdy[0] ? in_valid  : vld_ff[0];
      vld_in[1] = rdy[1] ? vld_ff[0] : vld_ff[1];
      vld_in[2] = rdy[2] ? vld_ff[1] : vld_ff[2];
      vld_in[3] = rdy[3] ? vld_ff[2] : vld_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 1
   always_comb begin
      part1_in = in_p;
      for (int i = 0; i < 3; i++) begin
         prod1_in[i] = $signed(in_p.vel[i]) * $signed({1'b0, in_dt});
      end
   end

   // stage 2: p += floor(v * dt)
   always_comb begin
      part2_in = part1_ff;
      for (int i = 0; i < 3; i++) begin
         pos_sum[i] = 64'($signed(part1_ff.pos[i])) + 64'(prod1_ff[i] >>> FRAC_BITS);
         part2_in.pos[i] = sat32(pos_sum[i]);
      end
   end

   // stage 3: floor(g2 * dt) split into integer and fraction parts of g2;
   // an integer part of 2^33 or more pins the result at the negative limit when dt is nonzero
   always_comb begin
      g2       = csr.gravity_sq >> FRAC_BITS;
      g2_hi    = g2 >> FRAC_BITS;
      hidt3_in = g2_hi[HI_W-1:0] * dt2_ff;
      lodt3_in = g2[FRAC_BITS-1:0] * dt2_ff;
      big3_in  = (|g2_hi[61:HI_W]) && (dt2_ff != '0);
   end

   // stage 4: v_y -= term
   always_comb begin
      part4_in = part3_ff;
      term     = 51'(hidt3_ff) + 51'(lodt3_ff >> FRAC_BITS);
      vy_diff  = 64'($signed(part3_ff.vel[1])) - $signed({13'b0, term});
      part4_in.vel[1] = big3_ff ? SAT_MIN : sat32(vy_diff);
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         part1_ff <= part1_in;
         dt1_ff   <= in_dt;
         for (int i = 0; i < 3; i++) begin
            prod1_ff[i] <= prod1_in[i];
         end
      end
      if (rdy[1]) begin
         part2_ff <= part2_in;
         dt2_ff   <= dt1_ff;
      end
      if (rdy[2]) begin
         part3_ff <= part2_ff;
         hidt3_ff <= hidt3_in;
         lodt3_ff <= lodt3_in;
         big3_ff  <= big3_in;
      end
      if (rdy[3]) begin
         part4_ff <= part4_in;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[3];
   assign out_p     = part4_ff;

endmodule

`default_nettype wire

[hdl/peb_bounce.sv]
`default_nettype none

module peb_bounce #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  peb_pkg::particle_type  in_p,
   input  peb_pkg::csr_type       csr,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [2:0][31:0]       out_pos,
   output logic [2:0][31:0]       out_vel
);
   import peb_pkg::*;

   // 0.01 rounded to nearest
   localparam logic signed [33:0] MARGIN = 34'(((1 << FRAC_BITS) + 50) / 100);

   logic [3:0] vld_ff, vld_in, rdy;

   // stage 1: damping products
   particle_type       part1_ff;
   logic signed [49:0] dprod1_ff [3];
   logic signed [49:0] dprod1_in [3];
   // stage 2: damped velocity, wall test, clamp bounds
   logic [2:0][31:0]   pos2_ff;
   logic [2:0][31:0]   vd2_ff, vd2_in;
   logic [2:0]         hit2_ff, hit2_in;
   logic signed [33:0] lo2_ff [3];
   logic signed [33:0] lo2_in [3];
   logic signed [33:0] hi2_ff [3];
   logic signed [33:0] hi2_in [3];
   // stage 3: bounce product, clamped position
   logic [2:0][31:0]   pos3_ff, pos3_in;
   logic [2:0][31:0]   vd3_ff;
   logic [2:0]         hit3_ff;
   logic signed [50:0] bprod3_ff [3];
   logic signed [50:0] bprod3_in [3];
   // stage 4: output register
   logic [2:0][31:0]   pos4_ff;
   logic [2:0][31:0]   vel4_ff, vel4_in;

   logic signed [33:0] p34 [3];
   logic signed [33:0] s34 [3];
   logic signed [33:0] h34 [3];
   logic signed [33:0] pc34 [3];
   logic signed [32:0] nv [3];

   always_comb begin
      rdy[3] = !vld_ff[3] || out_ready;
      rdy[2] = !vld_ff[2] || rdy[3];
      rdy[1] = !vld_ff[1] || rdy[2];
      rdy[0] = !vld_ff[0] || rdy[1];
      vld_in[0] = rdy[0] ? in_valid  : vld_ff[0];
      vld_in[1] = rdy[1] ? vld_ff[0] : vld_ff[1];
      vld_in[2] = rdy[2] ? vld_ff[1] : vld_ff[2];
      vld_in[3] = rdy[3] ? vld_ff[2] : vld_ff[3];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // stage 1
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dprod1_in[i] = $signed(in_p.vel[i]) * $signed({1'b0, csr.damping});
      end
   end

   // stage 2
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vd2_in[i]  = sat32(64'(dprod1_ff[i] >>> FRAC_BITS));
         p34[i]     = 34'($signed(part1_ff.pos[i]));
         s34[i]     = $signed({3'b0, part1_ff.size[i]});
         h34[i]     = $signed({3'b0, csr.half_ext[i]});
         hit2_in[i] = (p34[i] + s34[i] > h34[i]) || (p34[i] - s34[i] < -h34[i]);
         lo2_in[i]  = -h34[i] + MARGIN + s34[i];
         hi2_in[i]  = h34[i] - MARGIN - s34[i];
      end
   end

   // stage 3: on an empty interval, a position below the low bound gets it, others the high bound
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nv[i]        = -33'($signed(vd2_ff[i]));
         bprod3_in[i] = nv[i] * $signed({1'b0, csr.damping});
         pc34[i]      = 34'($signed(pos2_ff[i]));
         if (pc34[i] < lo2_ff[i]) begin
            pc34[i] = lo2_ff[i];
         end else if (pc34[i] > hi2_ff[i]) begin
            pc34[i] = hi2_ff[i];
         end
         pos3_in[i] = hit2_ff[i] ? sat32(64'(pc34[i])) : pos2_ff[i];
      end
   end

   // stage 4
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vel4_in[i] = hit3_ff[i] ? sat32(64'(bprod3_ff[i] >>> FRAC_BITS)) : vd3_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         part1_ff <= in_p;
         for (int i = 0; i < 3; i++) begin
            dprod1_ff[i] <= dprod1_in[i];
         end
      end
      if (rdy[1]) begin
         pos2_ff <= part1_ff.pos;
         vd2_ff  <= vd2_in;
         hit2_ff <= hit2_in;
         for (int i = 0; i < 3; i++) begin
            lo2_ff[i] <= lo2_in[i];
            hi2_ff[i] <= hi2_in[i];
         end
      end
      if (rdy[2]) begin
         pos3_ff <= pos3_in;
         vd3_ff  <= vd2_ff;
         hit3_ff <= hit2_ff;
         for (int i = 0; i < 3; i++) begin
            bprod3_ff[i] <= bprod3_in[i];
         end
      end
      if (rdy[3]) begin
         pos4_ff <= pos3_ff;
         vel4_ff <= vel4_in;
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = vld_ff[3];
   assign out_pos   = pos4_ff;
   assign out_vel   = vel4_ff;

endmodule

`default_nettype wire

[hdl/particle_euler_bounce_step_top.sv]
// Euler step for one particle in a box with wall bounce, signed fixed point.
// Request channel (req_*): one beat is one particle: position, velocity,
//   half size and frame time. A beat is taken when req_valid && req_ready.
// Response channel (rsp_*): one beat per request beat, in order: new
//   position and velocity, saturated to 32 bits.
// CSR port: csr_write_en writes csr_wdata to the register at csr_index
//   (gravity, damping, half extents x/y/z); unused indexes are dropped.
//   Write only while the pipe is empty.
// Stages: the request passes eight registered stages to rsp_valid. Four do the
//   position move and gravity, four do damping and the wall bounce; each
//   stage holds at most one multiply bank.
// Throughput: one beat per cycle, sustained while rsp_ready stays high.
// Reset: clears every stage valid and loads the register defaults
//   (gravity 3.0, damping 1.0, half extents 10.0).
// Backpressure: with rsp_ready low the output beat holds and the stages
//   behind it keep filling bubbles; req_ready drops only when all eight
//   stages are full.
`default_nettype none

module particle_euler_bounce_step_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [31:0]               req_pos_x,
   input  logic signed [31:0]               req_pos_y,
   input  logic signed [31:0]               req_pos_z,
   input  logic signed [31:0]               req_vel_x,
   input  logic signed [31:0]               req_vel_y,
   input  logic signed [31:0]               req_vel_z,
   input  logic [30:0]                      req_size_x,
   input  logic [30:0]                      req_size_y,
   input  logic [30:0]                      req_size_z,
   input  logic [16:0]                      req_frame_time,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [31:0]               rsp_new_pos_x,
   output logic signed [31:0]               rsp_new_pos_y,
   output logic signed [31:0]               rsp_new_pos_z,
   output logic signed [31:0]               rsp_new_vel_x,
   output logic signed [31:0]               rsp_new_vel_y,
   output logic signed [31:0]               rsp_new_vel_z,

   input  logic                             csr_write_en,
   input  logic [peb_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [peb_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import peb_pkg::*;

   csr_type          csr;
   particle_type     req_part;
   particle_type     mid_part;
   logic             mid_valid, mid_ready;
   logic [2:0][31:0] out_pos, out_vel;

   assign req_part.pos  = {req_pos_z, req_pos_y, req_pos_x};
   assign req_part.vel  = {req_vel_z, req_vel_y, req_vel_x};
   assign req_part.size = {req_size_z, req_size_y, req_size_x};

   peb_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .csr          (csr)
   );

   // move, then gravity on v_y
   peb_integrate #(
      .FRAC_BITS (FRAC_BITS)
   ) u_integrate (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_p      (req_part),
      .in_dt     (req_frame_time),
      .csr       (csr),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_p     (mid_part)
   );

   // damping, then per-axis wall bounce and clamp
   peb_bounce #(
      .FRAC_BITS (FRAC_BITS)
   ) u_bounce (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_p      (mid_part),
      .csr       (csr),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_pos   (out_pos),
      .out_vel   (out_vel)
   );

   assign rsp_new_pos_x = $signed(out_pos[0]);
   assign rsp_new_pos_y = $signed(out_pos[1]);
   assign rsp_new_pos_z = $signed(out_pos[2]);
   assign rsp_new_vel_x = $signed(out_vel[0]);
   assign rsp_new_vel_y = $signed(out_vel[1]);
   assign rsp_new_vel_z = $signed(out_vel[2]);

`ifndef NO_ASSERTIONS
   // an empty or draining output stage must open the whole ready chain
   a_ready_chain: assert property (@(posedge clock) disable iff (reset)
      (rsp_ready || !rsp_valid) |-> req_ready)
      else $error("req_ready low with output stage free");

   // no response beat right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid set right after reset");

   // after reset the pipe is empty, so a request is taken at once
   a_reset_ready: assert property (@(posedge clock)
      $past(reset) && !reset |-> req_ready)
      else $error("req_ready low right after reset");
`endif

endmodule

`default_nettype wire
